[rtl/core/btmx_pkg.sv]
// Package for the binary trie max-xor block: action and status codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package btmx_pkg;
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_FRD, S_FWAIT, S_FCNT, S_DECIDE, S_RD, S_WAIT, S_QRD, S_QWAIT, S_OUT
  } state_e;
endpackage

[rtl/core/btmx_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module btmx_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/core/binary_trie_max_xor.sv]
// Binary trie max-xor block: multiset of keys in a node pool held in two RAMs.
// Depends on btmx_pkg and btmx_ram.
//
// Each beat walks the trie one level at a time: a read state, then one that uses the data,
// since the memories read through a register. Every operation first runs a find pass
// (S_FRD, S_FWAIT per level), which a missing link ends early. Insert and delete that go
// ahead then run an update pass (S_RD, S_WAIT) over the root and every node on the path,
// and delete stops it at the node it detaches. A query on a non-empty trie instead runs a
// walk (S_QRD, S_QWAIT) that ends at the last level or at a node with no children. S_IDLE
// accepts an item and S_OUT presents its result. Nodes of detached branches are never
// reused. The result register holds the beat until taken; the next item is accepted once
// that result is delivered.
`timescale 1ns / 1ps
module binary_trie_max_xor #(
  parameter int KEY_BITS   = 32,
  parameter int POOL_NODES = 65536,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [31:0] best_xor_o
);
  localparam int AW = $clog2(POOL_NODES);
  localparam int LW = $clog2(KEY_BITS + 1);
  localparam int FW = AW + 1;
  localparam int KW = (KEY_BITS > 32) ? KEY_BITS : 32;
  localparam int IW = $clog2(KW);

  btmx_pkg::state_e state_q, state_d;
  logic [1:0]      act_q;
  logic [KW-1:0]   key_q;
  logic [LW-1:0]   lvl_q, lvl_d;
  logic [AW-1:0]   node_q, node_d;
  logic            pres_q, pres_d;
  logic [FW-1:0]   free_q, free_d;
  logic [COUNT_BITS-1:0] nkeys_q, nkeys_d;
  logic [KW-1:0]   best_q, best_d;
  logic [1:0]      stat_q, stat_d;
  logic [LW-1:0]   need_q, need_d;
  logic            root_ok_q;
  logic            fresh_q, fresh_d;
  logic [AW-1:0]   par_q, par_d;
  logic [2*AW-1:0] par_links_q, par_links_d;
  logic            par_bit_q, par_bit_d;

  logic            lwe, cwe;
  logic [AW-1:0]   laddr, caddr;
  logic [2*AW-1:0] lwdata, lrdata, lrd;
  logic [COUNT_BITS-1:0] cwdata, crdata;

  btmx_ram #(.Width(2*AW), .Depth(POOL_NODES)) u_links (
    .clk_i, .we_i(lwe), .addr_i(laddr), .wdata_i(lwdata), .rdata_o(lrdata));
  btmx_ram #(.Width(COUNT_BITS), .Depth(POOL_NODES)) u_counts (
    .clk_i, .we_i(cwe), .addr_i(caddr), .wdata_i(cwdata), .rdata_o(crdata));

  // treat the root before its first write and freshly allocated nodes as empty
  assign lrd = ((node_q == '0 && !root_ok_q) || fresh_q) ? '0 : lrdata;

  logic [LW-1:0] lm1;
  logic [IW-1:0] bix;
  logic          kb;
  logic [AW-1:0] chs, cho;
  assign lm1 = lvl_q - LW'(1);
  assign bix = IW'(lm1);
  assign kb  = key_q[bix];
  assign chs = kb ? lrd[2*AW-1:AW] : lrd[AW-1:0];
  assign cho = kb ? lrd[AW-1:0] : lrd[2*AW-1:AW];

  logic [COUNT_BITS-1:0] crd, cinc, cdec;
  logic                  pres_w, ins_ok, cut;
  assign crd    = fresh_q ? '0 : crdata;
  assign cinc   = crd + COUNT_BITS'(1);
  assign cdec   = crd - COUNT_BITS'(1);
  assign cut    = (act_q == btmx_pkg::ACT_DELETE) && (node_q != '0) && (cdec == '0);
  assign pres_w = (lvl_q == '0) && (crdata != '0);
  assign ins_ok = (nkeys_q != '1) &&
                  (({1'b0, free_q} + (FW+1)'(need_q)) <= (FW+1)'(POOL_NODES));

  always_comb begin
    state_d = state_q;
    case (state_q)
      btmx_pkg::S_IDLE:   if (in_valid_i) state_d = btmx_pkg::S_FRD;
      btmx_pkg::S_FRD:    state_d = btmx_pkg::S_FWAIT;
      btmx_pkg::S_FWAIT: begin
        if (chs == '0) state_d = btmx_pkg::S_DECIDE;
        else if (lvl_q == LW'(1)) state_d = btmx_pkg::S_FCNT;
        else state_d = btmx_pkg::S_FRD;
      end
      btmx_pkg::S_FCNT:   state_d = btmx_pkg::S_DECIDE;
      btmx_pkg::S_DECIDE: begin
        state_d = btmx_pkg::S_OUT;
        case (act_q)
          btmx_pkg::ACT_INSERT: if (ins_ok) state_d = btmx_pkg::S_RD;
          btmx_pkg::ACT_DELETE: if (pres_w) state_d = btmx_pkg::S_RD;
          btmx_pkg::ACT_QUERY:  if (nkeys_q != '0) state_d = btmx_pkg::S_QRD;
          default: ;
        endcase
      end
      btmx_pkg::S_RD:   state_d = btmx_pkg::S_WAIT;
      btmx_pkg::S_WAIT: begin
        if (lvl_q == '0 || cut) state_d = btmx_pkg::S_OUT;
        else state_d = btmx_pkg::S_RD;
      end
      btmx_pkg::S_QRD:   state_d = btmx_pkg::S_QWAIT;
      btmx_pkg::S_QWAIT: begin
        if (lvl_q == LW'(1) || (cho == '0 && chs == '0)) state_d = btmx_pkg::S_OUT;
        else state_d = btmx_pkg::S_QRD;
      end
      btmx_pkg::S_OUT: if (out_ready_i) state_d = btmx_pkg::S_IDLE;
      default: state_d = btmx_pkg::S_IDLE;
    endcase
  end

  logic [AW-1:0]   nn;
  logic [2*AW-1:0] upd;
  always_comb begin
    lvl_d = lvl_q; node_d = node_q; pres_d = pres_q;
    free_d = free_q; nkeys_d = nkeys_q; best_d = best_q; stat_d = stat_q;
    need_d = need_q; fresh_d = fresh_q;
    par_d = par_q; par_links_d = par_links_q; par_bit_d = par_bit_q;
    lwe = 1'b0; cwe = 1'b0; laddr = node_q; caddr = node_q;
    lwdata = '0; cwdata = '0;
    nn = free_q[AW-1:0];
    upd = lrd;
    case (state_q)
      btmx_pkg::S_IDLE: begin
        lvl_d = LW'(KEY_BITS); node_d = '0; pres_d = 1'b0; need_d = '0;
        best_d = '0; stat_d = btmx_pkg::ST_DONE; fresh_d = 1'b0;
      end
      btmx_pkg::S_FWAIT: begin
        if (chs == '0) need_d = lvl_q;
        else begin
          node_d = chs; lvl_d = lm1;
        end
      end
      btmx_pkg::S_FCNT: caddr = node_q;
      btmx_pkg::S_DECIDE: begin
        pres_d = pres_w;
        lvl_d = LW'(KEY_BITS); node_d = '0;
        case (act_q)
          btmx_pkg::ACT_INSERT:
            if (!ins_ok) stat_d = btmx_pkg::ST_FULL;
            else nkeys_d = nkeys_q + 1'b1;
          btmx_pkg::ACT_DELETE:
            if (!pres_w) stat_d = btmx_pkg::ST_ABSENT;
            else nkeys_d = nkeys_q - 1'b1;
          btmx_pkg::ACT_FIND: if (!pres_w) stat_d = btmx_pkg::ST_ABSENT;
          default: if (nkeys_q == '0) stat_d = btmx_pkg::ST_ABSENT;
        endcase
      end
      btmx_pkg::S_RD: caddr = node_q;
      btmx_pkg::S_WAIT: begin
        if (node_q != '0) begin
          cwe = 1'b1;
          cwdata = (act_q == btmx_pkg::ACT_INSERT) ? cinc : cdec;
        end
        if (cut) begin
          // detach the emptied branch from its parent
          upd = par_links_q;
          if (par_bit_q) upd[2*AW-1:AW] = '0; else upd[AW-1:0] = '0;
          lwe = 1'b1; laddr = par_q; lwdata = upd;
        end else if (lvl_q != '0) begin
          if (act_q == btmx_pkg::ACT_INSERT && chs == '0) begin
            // allocate: fresh node, link from parent
            if (kb) upd[2*AW-1:AW] = nn; else upd[AW-1:0] = nn;
            lwe = 1'b1; laddr = node_q; lwdata = upd;
            free_d = free_q + FW'(1);
            node_d = nn; fresh_d = 1'b1;
          end else node_d = chs;
          par_d = node_q; par_links_d = lrd; par_bit_d = kb;
          lvl_d = lm1;
        end
      end
      btmx_pkg::S_QWAIT: begin
        if (cho != '0) begin
          best_d = best_q | (KW'(1) << lm1); node_d = cho;
        end else node_d = chs;
        lvl_d = lm1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btmx_pkg::S_IDLE;
      free_q <= FW'(1); nkeys_q <= '0; root_ok_q <= 1'b0;
      lvl_q <= '0; node_q <= '0; pres_q <= 1'b0; best_q <= '0;
      stat_q <= '0; need_q <= '0; act_q <= '0; key_q <= '0;
      fresh_q <= 1'b0; par_q <= '0; par_links_q <= '0; par_bit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q <= free_d; nkeys_q <= nkeys_d;
      lvl_q <= lvl_d; node_q <= node_d; pres_q <= pres_d; best_q <= best_d;
      stat_q <= stat_d; need_q <= need_d;
      fresh_q <= fresh_d; par_q <= par_d; par_links_q <= par_links_d;
      par_bit_q <= par_bit_d;
      if (lwe && laddr == '0) root_ok_q <= 1'b1;
      if (state_q == btmx_pkg::S_IDLE && in_valid_i) begin
        act_q <= action_i; key_q <= KW'(key_i);
      end
    end
  end

  assign in_ready_o  = (state_q == btmx_pkg::S_IDLE);
  assign out_valid_o = (state_q == btmx_pkg::S_OUT);
  assign status_o    = stat_q;
  assign found_o     = pres_q;
  assign best_xor_o  = (stat_q == btmx_pkg::ST_DONE) ? best_q[31:0] : 32'd0;
endmodule

[dv/binary_trie_max_xor_tb.sv]
// Testbench for binary_trie_max_xor: random and directed insert, delete, find and query beats
// checked against a behavioural trie model held in associative arrays.
// Depends on btmx_pkg and the binary_trie_max_xor RTL.
`timescale 1ns / 1ps
module binary_trie_max_xor_tb;

  localparam int KEY_BITS   = 32;
  localparam int POOL_NODES = 65536;
  localparam int COUNT_MAX  = 65535;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
  } op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] best_xor;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [31:0] key_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic        found_o;
  logic [31:0] best_xor_o;

  binary_trie_max_xor dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .key_i,
    .out_valid_o, .out_ready_i, .status_o, .found_o, .best_xor_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // trie model: links keyed by node*2+bit, absent entry means no child
  int unsigned link_tbl [longint unsigned];
  int unsigned cnt_tbl [int unsigned];
  int unsigned free_node = 1;
  int unsigned key_total = 0;

  op_t  pending_ops [$];
  res_t expected_res [$];
  logic [31:0] stored_pool [$];
  int   errors = 0;
  bit   hold_send = 1'b0;
  bit   in_acc = 1'b0;
  bit   out_acc = 1'b0;

  function automatic int unsigned child_of(int unsigned n, bit b);
    longint unsigned ix;
    ix = {n, b};
    if (link_tbl.exists(ix)) return link_tbl[ix];
    return 0;
  endfunction

  function automatic bit trie_has(logic [31:0] k);
    int unsigned n;
    n = 0;
    for (int l = KEY_BITS - 1; l >= 0; l--) begin
      n = child_of(n, k[l]);
      if (n == 0) return 1'b0;
    end
    return cnt_tbl[n] != 0;
  endfunction

  function automatic int unsigned nodes_missing(logic [31:0] k);
    int unsigned n, c;
    n = 0;
    for (int l = KEY_BITS - 1; l >= 0; l--) begin
      c = child_of(n, k[l]);
      if (c == 0) return l + 1;
      n = c;
    end
    return 0;
  endfunction

  function automatic res_t trie_apply(op_t op);
    res_t r;
    int unsigned n, c;
    bit b;
    r = '0;
    r.found = trie_has(op.key);
    case (op.action)
      btmx_pkg::ACT_INSERT: begin
        if (key_total >= COUNT_MAX || free_node + nodes_missing(op.key) > POOL_NODES) begin
          r.status = btmx_pkg::ST_FULL;
        end else begin
          n = 0;
          for (int l = KEY_BITS - 1; l >= 0; l--) begin
            b = op.key[l];
            c = child_of(n, b);
            if (c == 0) begin
              c = free_node++;
              cnt_tbl[c] = 0;
              link_tbl[{n, b}] = c;
            end
            n = c;
            cnt_tbl[n]++;
          end
          key_total++;
          r.status = btmx_pkg::ST_DONE;
        end
      end
      btmx_pkg::ACT_DELETE: begin
        if (!r.found) begin
          r.status = btmx_pkg::ST_ABSENT;
        end else begin
          n = 0;
          for (int l = KEY_BITS - 1; l >= 0; l--) begin
            b = op.key[l];
            c = child_of(n, b);
            if (c == 0) break;
            cnt_tbl[c]--;
            if (cnt_tbl[c] == 0) begin
              link_tbl.delete({n, b});
              break;
            end
            n = c;
          end
          key_total--;
          r.status = btmx_pkg::ST_DONE;
        end
      end
      btmx_pkg::ACT_FIND: r.status = r.found ? btmx_pkg::ST_DONE : btmx_pkg::ST_ABSENT;
      default: begin
        if (key_total == 0) begin
          r.status = btmx_pkg::ST_ABSENT;
        end else begin
          n = 0;
          for (int l = KEY_BITS - 1; l >= 0; l--) begin
            b = op.key[l];
            c = child_of(n, !b);
            if (c != 0) begin
              r.best_xor[l] = 1'b1;
              n = c;
            end else begin
              c = child_of(n, b);
              if (c == 0) break;
              n = c;
            end
          end
          r.status = btmx_pkg::ST_DONE;
        end
      end
    endcase
    return r;
  endfunction

  // driver
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc) begin
        in_valid_i <= 1'b0;
        send_gap <= $urandom_range(0, 9);
      end else if (!in_valid_i) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (!hold_send && pending_ops.size() > 0) begin
          in_valid_i <= 1'b1;
          action_i <= pending_ops[0].action;
          key_i <= pending_ops[0].key;
          pending_ops.delete(0);
        end
      end
    end
  end

  // receiver stall
  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_acc) begin
        out_ready_i <= 1'b0;
        recv_gap <= $urandom_range(0, 9);
      end else if (!out_ready_i) begin
        if (recv_gap > 0) recv_gap <= recv_gap - 1;
        else out_ready_i <= 1'b1;
      end
    end
  end

  // predict on each input beat, then check each output beat
  always @(posedge clk_i) begin
    op_t  cur;
    res_t got, want;
    in_acc  <= rst_ni && in_valid_i && in_ready_o;
    out_acc <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && in_valid_i && in_ready_o) begin
      cur = '{action: action_i, key: key_i};
      expected_res = {expected_res, trie_apply(cur)};
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status: status_o, found: found_o, best_xor: best_xor_o};
      if (expected_res.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: status %0d found %0d xor %h",
                                   got.status, got.found, got.best_xor);
      end else begin
        want = expected_res[0];
        expected_res.delete(0);
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp status %0d found %0d xor %h, got %0d %0d %h",
                     want.status, want.found, want.best_xor,
                     got.status, got.found, got.best_xor);
        end
      end
    end
  end

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 15);
      2: return {2'($urandom_range(0, 3)), 30'(0)} | 32'($urandom_range(0, 7));
      default: begin
        if (stored_pool.size() == 0) return $urandom;
        return stored_pool[$urandom_range(0, stored_pool.size() - 1)] ^
               (($urandom_range(0, 3) == 0) ? (32'h1 << $urandom_range(0, 31)) : 32'h0);
      end
    endcase
  endfunction

  function automatic void push_op(logic [1:0] a, logic [31:0] k);
    op_t op;
    op = '{action: a, key: k};
    pending_ops = {pending_ops, op};
    if (a == btmx_pkg::ACT_INSERT && stored_pool.size() < 64) stored_pool = {stored_pool, k};
  endfunction

  initial begin
    int pick;
    logic [1:0] a;
    // query, delete and find on empty trie, extremes, duplicates
    push_op(btmx_pkg::ACT_QUERY, 32'h0);
    push_op(btmx_pkg::ACT_DELETE, 32'hFFFF_FFFF);
    push_op(btmx_pkg::ACT_FIND, 32'h0);
    push_op(btmx_pkg::ACT_INSERT, 32'h0);
    push_op(btmx_pkg::ACT_INSERT, 32'hFFFF_FFFF);
    push_op(btmx_pkg::ACT_INSERT, 32'hFFFF_FFFF);
    push_op(btmx_pkg::ACT_QUERY, 32'h0);
    push_op(btmx_pkg::ACT_QUERY, 32'hFFFF_FFFF);
    push_op(btmx_pkg::ACT_QUERY, 32'h5555_AAAA);
    push_op(btmx_pkg::ACT_FIND, 32'hFFFF_FFFF);
    push_op(btmx_pkg::ACT_FIND, 32'h8000_0000);
    push_op(btmx_pkg::ACT_DELETE, 32'hFFFF_FFFF);
    push_op(btmx_pkg::ACT_FIND, 32'hFFFF_FFFF);
    push_op(btmx_pkg::ACT_DELETE, 32'hFFFF_FFFF);
    push_op(btmx_pkg::ACT_FIND, 32'hFFFF_FFFF);
    push_op(btmx_pkg::ACT_DELETE, 32'hFFFF_FFFE);
    push_op(btmx_pkg::ACT_DELETE, 32'h0);
    push_op(btmx_pkg::ACT_QUERY, 32'h1234_5678);
    push_op(btmx_pkg::ACT_INSERT, 32'h8000_0001);
    push_op(btmx_pkg::ACT_QUERY, 32'h8000_0001);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_ops.size() == 0 && !in_valid_i);
    hold_send = 1'b1;
    wait (expected_res.size() == 0);
    hold_send = 1'b0;
    for (int i = 0; i < 1500; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) a = btmx_pkg::ACT_INSERT;
      else if (pick < 6) a = btmx_pkg::ACT_DELETE;
      else if (pick < 8) a = btmx_pkg::ACT_FIND;
      else a = btmx_pkg::ACT_QUERY;
      push_op(a, pick_key());
    end
    wait (pending_ops.size() == 0 && !in_valid_i);
    wait (expected_res.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_res.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end
endmodule

[sim.f]
rtl/core/btmx_pkg.sv
rtl/core/btmx_ram.sv
rtl/core/binary_trie_max_xor.sv
dv/binary_trie_max_xor_tb.sv
